/* rtl/crlog_pkg.sv */
// crlog_pkg: shared types, constants and the bytewise crc-32 step for the
// circular record log. No dependencies.
`default_nettype none

package crlog_pkg;

   localparam int REC_W     = 128;
   localparam int AGE_W     = 6;
   localparam int HDR_BYTES = 8;
   localparam int CRC_BYTES = 4;
   localparam int REC_SHIFT = 4;   // 16 bytes per record
   localparam int IN_DATA_W  = 136;
   localparam int OUT_DATA_W = 144;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // reflected crc-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc_i,
                                              input logic [7:0] data_i);
      logic [31:0] c;
      c = crc_i ^ {24'd0, data_i};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/crlog_ram.sv */
// crlog_ram: generic simple dual-port ram, one write and one registered read port.
// No dependencies.
`default_nettype none

module crlog_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/circular_record_log_with_crc_dump_unit.sv */
// A response beat is formed in the execute state after its accept, then registered.
// A new request is taken only in the idle state, with record ram access, not in execute
//   (byte select, crc-32 step); a held response keeps req_tready low until it is taken.
// Reset clears write pointer, record count, dump cursor, crc and magic word;
//   the record ram is not cleared and needs no clearing pass.
// Depends on crlog_pkg and crlog_ram.
`default_nettype none

module circular_record_log_with_crc_dump_unit
   import crlog_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request: tdata = timestamp_secs[31:0], origin_code[39:32], action_code[47:40],
   //   target_code[55:48], outcome_code[63:56], node_id[95:64],
   //   sequence_number[127:96], age_index[133:128], zero pad [135:134]
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [IN_DATA_W-1:0]    req_tdata,
   input  wire logic [1:0]              req_tuser,   // op[1:0]
   // response: tdata = found[0], rd_timestamp[32:1], rd_origin[40:33],
   //   rd_action[48:41], rd_target[56:49], rd_outcome[64:57], rd_node[96:65],
   //   rd_sequence[128:97], dump_byte[136:129], zero pad [143:137]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [OUT_DATA_W-1:0]        rsp_tdata,
   output logic                         rsp_tlast,   // dump_last
   // configuration
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [2:0]              csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic      [31:0]             csr_prdata,
   output logic                         csr_pready
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int CW   = $clog2(16 * CAPACITY + HDR_BYTES + CRC_BYTES);
   localparam int CMPW = (CNTW > AGE_W) ? CNTW : AGE_W;

   // state
   state_type         state_ff, state_in;
   logic [AW-1:0]     wptr_ff, wptr_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [CNTW-1:0]   total_ff, total_in;
   logic [AW-1:0]     dptr_ff, dptr_in;
   logic [31:0]       crc_ff, crc_in;
   logic [31:0]       magic_ff, magic_in;

   // work carried from accept to execute
   op_type            pend_op_ff, pend_op_in;
   logic              pend_found_ff, pend_found_in;
   logic              pend_mem_ff, pend_mem_in;
   logic [3:0]        pend_off_ff, pend_off_in;
   logic [7:0]        pend_byte_ff, pend_byte_in;
   logic              pend_crc_ff, pend_crc_in;
   logic              pend_last_ff, pend_last_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ram ports
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [REC_W-1:0]  ram_rd_data;

   logic              accept;
   op_type            req_op;
   logic [AGE_W-1:0]  req_age;
   logic              cur0;
   logic [CNTW-1:0]   tot;
   logic [CW-1:0]     body_end;
   logic [15:0]       tot16;
   logic [AW:0]       read_sum;
   logic [AW-1:0]     read_slot;
   logic [AW:0]       start_sum;
   logic [AW-1:0]     start_slot;
   logic [3:0]        body_off;
   logic              in_body;
   logic [7:0]        out_byte;
   logic [31:0]       crc_fin;

   assign req_op  = op_type'(req_tuser);
   assign req_age = req_tdata[REC_W +: AGE_W];
   assign accept  = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? magic_ff : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // dump geometry seen at accept
   assign cur0     = (cursor_ff == '0);
   assign tot      = cur0 ? count_ff : total_ff;
   assign tot16    = 16'(tot);
   assign body_end = CW'({tot, 4'b0000}) + CW'(HDR_BYTES);
   assign body_off = 4'(cursor_ff - CW'(HDR_BYTES));
   assign in_body  = (cursor_ff >= CW'(HDR_BYTES)) && (cursor_ff < body_end);
   assign crc_fin  = ~crc_ff;

   // slot of age a: (wptr + CAPACITY - 1 - a) mod CAPACITY, a below count
   assign read_sum  = (AW+1)'(wptr_ff) + (AW+1)'(CAPACITY - 1) - (AW+1)'(req_age);
   assign read_slot = (read_sum >= (AW+1)'(CAPACITY)) ?
                      AW'(read_sum - (AW+1)'(CAPACITY)) : AW'(read_sum);
   // oldest record slot at dump start
   assign start_sum  = (AW+1)'(wptr_ff) + (AW+1)'(CAPACITY) - (AW+1)'(count_ff);
   assign start_slot = (start_sum >= (AW+1)'(CAPACITY)) ?
                       AW'(start_sum - (AW+1)'(CAPACITY)) : AW'(start_sum);

   assign ram_wr_en   = accept && (req_op == OP_APPEND);
   assign ram_rd_en   = accept && ((req_op == OP_READ) || ((req_op == OP_DUMP) && in_body));
   assign ram_rd_addr = (req_op == OP_READ) ? read_slot : dptr_ff;

   assign out_byte = pend_mem_ff ? ram_rd_data[{pend_off_ff, 3'b000} +: 8] : pend_byte_ff;

   always_comb begin
      state_in      = state_ff;
      wptr_in       = wptr_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      total_in      = total_ff;
      dptr_in       = dptr_ff;
      crc_in        = crc_ff;
      magic_in      = magic_ff;
      pend_op_in    = pend_op_ff;
      pend_found_in = pend_found_ff;
      pend_mem_in   = pend_mem_ff;
      pend_off_in   = pend_off_ff;
      pend_byte_in  = pend_byte_ff;
      pend_crc_in   = pend_crc_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      req_tready    = 1'b0;

      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0)) begin
         magic_in = csr_pwdata;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (accept) begin
               state_in      = ST_EXEC;
               pend_op_in    = req_op;
               pend_found_in = (CMPW'(req_age) < CMPW'(count_ff));
               pend_mem_in   = 1'b0;
               pend_off_in   = body_off;
               pend_byte_in  = 8'd0;
               pend_crc_in   = 1'b0;
               pend_last_in  = 1'b0;
               case (req_op)
                  OP_APPEND: begin
                     wptr_in   = (wptr_ff == AW'(CAPACITY - 1)) ? '0 : wptr_ff + AW'(1);
                     if (count_ff < CNTW'(CAPACITY)) begin
                        count_in = count_ff + CNTW'(1);
                     end
                     cursor_in = '0;
                     crc_in    = CRC_INIT;
                  end
                  OP_CLEAR: begin
                     wptr_in   = '0;
                     count_in  = '0;
                     cursor_in = '0;
                     crc_in    = CRC_INIT;
                  end
                  OP_DUMP: begin
                     total_in = tot;
                     if (cur0) begin
                        crc_in  = CRC_INIT;
                        dptr_in = start_slot;
                     end else if (in_body && (body_off == 4'hF)) begin
                        dptr_in = (dptr_ff == AW'(CAPACITY - 1)) ? '0 : dptr_ff + AW'(1);
                     end
                     if (cursor_ff < CW'(4)) begin
                        pend_byte_in = magic_ff[{cursor_ff[1:0], 3'b000} +: 8];
                     end else if (cursor_ff < CW'(6)) begin
                        pend_byte_in = tot16[{cursor_ff[0], 3'b000} +: 8];
                     end else if (cursor_ff >= body_end) begin
                        // body_end is a multiple of four
                        pend_byte_in = crc_fin[{cursor_ff[1:0], 3'b000} +: 8];
                     end
                     pend_mem_in = in_body;
                     pend_crc_in = (cursor_ff < body_end);
                     if (cursor_ff == body_end + CW'(CRC_BYTES - 1)) begin
                        pend_last_in = 1'b1;
                        cursor_in    = '0;
                        crc_in       = CRC_INIT;
                     end else begin
                        cursor_in = cursor_ff + CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_last_in  = 1'b0;
            case (pend_op_ff)
               OP_READ: begin
                  if (pend_found_ff) begin
                     rsp_data_in[0]       = 1'b1;
                     rsp_data_in[REC_W:1] = ram_rd_data;
                  end
               end
               OP_DUMP: begin
                  rsp_data_in[REC_W+1 +: 8] = out_byte;
                  rsp_last_in = pend_last_ff;
                  if (pend_crc_ff) begin
                     crc_in = crc32_byte(crc_ff, out_byte);
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         count_ff     <= '0;
         cursor_ff    <= '0;
         total_ff     <= '0;
         dptr_ff      <= '0;
         crc_ff       <= CRC_INIT;
         magic_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         total_ff     <= total_in;
         dptr_ff      <= dptr_in;
         crc_ff       <= crc_in;
         magic_ff     <= magic_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_op_ff    <= pend_op_in;
      pend_found_ff <= pend_found_in;
      pend_mem_ff   <= pend_mem_in;
      pend_off_ff   <= pend_off_in;
      pend_byte_ff  <= pend_byte_in;
      pend_crc_ff   <= pend_crc_in;
      pend_last_ff  <= pend_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   crlog_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wptr_ff),
      .wr_data (req_tdata[REC_W-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef ASSERT_OFF
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted beat not followed by execute cycle");

   a_out_free_in_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !rsp_valid_ff)
      else $error("output register busy while a result is produced");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNTW'(CAPACITY)) && ((AW+1)'(wptr_ff) < (AW+1)'(CAPACITY)))
      else $error("record count or write pointer out of range");

   a_last_only_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_data_ff[0] == 1'b0))
      else $error("dump end marked on a read result");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff != '0) |-> (cursor_ff < CW'({total_ff, 4'b0000}) + CW'(HDR_BYTES + CRC_BYTES)))
      else $error("dump cursor beyond image");
`endif

endmodule

`default_nettype wire

/* sim/circular_record_log_with_crc_dump_unit_test.sv */
// Self-checking testbench for the circular record log with crc-32 image dump.
// Drives request beats and apb writes, predicts every response beat in-line.
// Depends on crlog_pkg and the circular_record_log_with_crc_dump_unit rtl.

module circular_record_log_with_crc_dump_unit_test;
   import crlog_pkg::*;

   localparam int LOG_DEPTH    = 64;
   localparam int REC_BYTES    = 16;
   localparam int DIR_ROWS     = 25;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_TICKS  = 400000;
   localparam logic [2:0] CSR_MAGIC_ADDR = 3'd0;
   localparam logic [2:0] CSR_SPARE_ADDR = 3'd4;   // no register behind it

   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] node;
      logic [7:0]  outcome;
      logic [7:0]  target;
      logic [7:0]  action;
      logic [7:0]  origin;
      logic [31:0] stamp;
   } log_rec_t;

   typedef struct packed {
      op_type      op;
      logic [5:0]  age;
      log_rec_t    rec;
   } req_item_t;

   // lower 137 bits match the response tdata layout, last rides on tlast
   typedef struct packed {
      logic        last;
      logic [7:0]  dbyte;
      log_rec_t    rec;
      logic        found;
   } rsp_item_t;

   typedef struct packed {
      req_item_t   item;
      logic        lit;
      rsp_item_t   want;
   } dir_row_t;

   localparam log_rec_t  ALL_ONES_REC = '1;
   localparam log_rec_t  MARK_REC     = 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;
   localparam rsp_item_t NO_HIT       = '0;
   localparam rsp_item_t ONES_HIT     = '{1'b0, 8'h00, ALL_ONES_REC, 1'b1};
   localparam rsp_item_t ZERO_HIT     = '{1'b0, 8'h00, 128'h0, 1'b1};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [IN_DATA_W-1:0]   req_tdata = '0;
   logic [1:0]             req_tuser = OP_APPEND;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [2:0]             csr_paddr = CSR_MAGIC_ADDR;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   circular_record_log_with_crc_dump_unit #(.CAPACITY(LOG_DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the log and of the dump walk
   log_rec_t    ring_mem [LOG_DEPTH];
   int          ring_wr = 0;
   int          ring_count = 0;
   int          img_pos = 0;
   int          img_recs = 0;
   logic [31:0] img_crc = '1;
   logic [31:0] magic_shadow = '0;
   bit          image_done = 1'b0;

   rsp_item_t   pending_rsp [$];
   int          mis_count = 0;
   int          items_sent = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_len = 0;
   int          hold_seq = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   rsp_item_t   got_rsp;
   rsp_item_t   want_rsp;

   dir_row_t directed_rows [DIR_ROWS] = '{
      '{'{OP_READ,   6'd0,  '0}, 1'b1, NO_HIT},      // empty log, newest
      '{'{OP_READ,   6'd63, '0}, 1'b1, NO_HIT},      // empty log, oldest age
      '{'{OP_DUMP,   6'd0,  '0}, 1'b1, NO_HIT},      // magic 0, count 0, pad
      '{'{OP_DUMP,   6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b0, NO_HIT},      // crc bytes
      '{'{OP_DUMP,   6'd0,  '0}, 1'b0, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b0, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b0, NO_HIT},
      '{'{OP_APPEND, 6'd63, ALL_ONES_REC}, 1'b1, NO_HIT},
      '{'{OP_APPEND, 6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_READ,   6'd1,  '0}, 1'b1, ONES_HIT},
      '{'{OP_READ,   6'd0,  '1}, 1'b1, ZERO_HIT},
      '{'{OP_READ,   6'd2,  '0}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b0, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b0, NO_HIT},
      '{'{OP_CLEAR,  6'd0,  '0}, 1'b1, NO_HIT},      // clear mid image
      '{'{OP_READ,   6'd0,  '0}, 1'b1, NO_HIT},
      '{'{OP_APPEND, 6'd0,  MARK_REC}, 1'b1, NO_HIT},
      '{'{OP_DUMP,   6'd0,  '0}, 1'b0, NO_HIT}
   };

   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      return c;
   endfunction

   function automatic int slot_for_age(input int age);
      return (ring_wr + LOG_DEPTH - 1 - age) % LOG_DEPTH;
   endfunction

   function automatic string rsp_text(input rsp_item_t r);
      return $sformatf("found=%0d ts=%h org=%h act=%h tgt=%h res=%h node=%h seq=%h byte=%h last=%0d",
                       r.found, r.rec.stamp, r.rec.origin, r.rec.action, r.rec.target,
                       r.rec.outcome, r.rec.node, r.rec.seq, r.dbyte, r.last);
   endfunction

   task automatic log_predict(input req_item_t it, output rsp_item_t r);
      int          body_end;
      int          k;
      int          off;
      logic [7:0]  b;
      logic [31:0] fin;
      logic [15:0] hdr_cnt;
      r = '0;
      case (it.op)
         OP_APPEND: begin
            ring_mem[ring_wr] = it.rec;
            ring_wr = (ring_wr + 1) % LOG_DEPTH;
            if (ring_count < LOG_DEPTH) ring_count++;
            img_pos = 0;
            img_crc = '1;
         end
         OP_READ: begin
            if (it.age < ring_count) begin
               r.found = 1'b1;
               r.rec = ring_mem[slot_for_age(it.age)];
            end
         end
         OP_CLEAR: begin
            ring_count = 0;
            ring_wr = 0;
            img_pos = 0;
            img_crc = '1;
         end
         default: begin
            // count is latched when a new image starts
            if (img_pos == 0) begin
               img_recs = ring_count;
               img_crc = '1;
            end
            body_end = HDR_BYTES + REC_BYTES * img_recs;
            hdr_cnt = 16'(img_recs);
            if (img_pos < 4) begin
               b = magic_shadow[8*img_pos +: 8];
            end else if (img_pos < 6) begin
               b = hdr_cnt[8*(img_pos-4) +: 8];
            end else if (img_pos < HDR_BYTES) begin
               b = 8'h00;
            end else if (img_pos < body_end) begin
               k = (img_pos - HDR_BYTES) / REC_BYTES;
               off = (img_pos - HDR_BYTES) % REC_BYTES;
               b = ring_mem[slot_for_age(img_recs - 1 - k)][8*off +: 8];
            end else begin
               fin = ~img_crc;
               b = fin[8*((img_pos - body_end) % 4) +: 8];
            end
            if (img_pos < body_end) img_crc = crc_step(img_crc, b);
            r.dbyte = b;
            if (img_pos + 1 >= body_end + CRC_BYTES) begin
               r.last = 1'b1;
               img_pos = 0;
               img_crc = '1;
               image_done = 1'b1;
            end else begin
               img_pos++;
            end
         end
      endcase
   endtask

   function automatic req_item_t make_item(input op_type op);
      req_item_t it;
      it.op = op;
      it.rec = {$urandom, $urandom, $urandom, $urandom};
      if (op == OP_READ && ring_count > 0 && $urandom_range(99) < 80) begin
         it.age = 6'($urandom_range(ring_count - 1));
      end else begin
         it.age = 6'($urandom_range(63));
      end
      return it;
   endfunction

   // one request beat; called right after a rising edge
   task automatic push_req(input req_item_t it, input logic lit, input rsp_item_t lit_rsp);
      rsp_item_t want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= {2'b00, it.age, it.rec};
      do @(posedge clock); while (req_tready !== 1'b1);
      log_predict(it, want);
      pending_rsp.push_back(lit ? lit_rsp : want);
      items_sent++;
   endtask

   task automatic send_item(input req_item_t it);
      push_req(it, 1'b0, NO_HIT);
   endtask

   task automatic send_op(input op_type op);
      send_item(make_item(op));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // apb write, then read the magic register back
   task automatic program_magic(input logic [2:0] addr, input logic [31:0] val);
      logic [31:0] rd;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_MAGIC_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rd = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == CSR_MAGIC_ADDR) magic_shadow = val;
      if (rd !== magic_shadow) begin
         mis_count++;
         if (mis_count <= 10) $display("magic readback: want %h got %h", magic_shadow, rd);
      end
   endtask

   task automatic run_random(input int quota);
      int        stop_at;
      int        pick;
      int        n;
      req_item_t it;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            // short log, then the whole image with a few reads mixed in
            if (ring_count > 4 || $urandom_range(1)) send_op(OP_CLEAR);
            n = $urandom_range(4);
            repeat (n) send_op(OP_APPEND);
            image_done = 1'b0;
            while (!image_done) begin
               if ($urandom_range(99) < 20) send_op(OP_READ);
               else send_op(OP_DUMP);
            end
         end else if (pick < 55) begin
            repeat ($urandom_range(5, 15)) send_op(OP_READ);
         end else if (pick < 75) begin
            repeat (10) send_op(op_type'($urandom_range(3)));
         end else if (pick < 87) begin
            // image cut short by an append or a clear
            repeat ($urandom_range(1, 30)) send_op(OP_DUMP);
            send_op($urandom_range(1) ? OP_APPEND : OP_CLEAR);
         end else if (pick < 94) begin
            // append 20 to 70 records, which can fill past capacity so the ring wraps
            repeat ($urandom_range(20, 70)) send_op(OP_APPEND);
            it = make_item(OP_READ);
            it.age = 6'd63;
            send_item(it);
            repeat (4) send_op(OP_READ);
            repeat (10) send_op(OP_DUMP);
         end else begin
            // new magic while an image is partly sent
            send_op(OP_CLEAR);
            repeat ($urandom_range(1, 2)) send_op(OP_APPEND);
            repeat (3) send_op(OP_DUMP);
            wait_idle();
            program_magic(CSR_MAGIC_ADDR, $urandom);
            image_done = 1'b0;
            while (!image_done) send_op(OP_DUMP);
         end
      end
   endtask

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got_rsp = {rsp_tlast, rsp_tdata[136:0]};
         if (pending_rsp.size() == 0) begin
            mis_count++;
            if (mis_count <= 10) $display("unexpected beat: %s", rsp_text(got_rsp));
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (got_rsp !== want_rsp) begin
               mis_count++;
               if (mis_count <= 10) begin
                  $display("mismatch want: %s", rsp_text(want_rsp));
                  $display("         got:  %s", rsp_text(got_rsp));
               end
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         push_req(directed_rows[i].item, directed_rows[i].lit, directed_rows[i].want);
      end

      wait_idle();
      program_magic(CSR_MAGIC_ADDR, 32'hFFFF_FFFF);
      send_idle_pct = 15;
      recv_idle_pct = 78;
      run_random(440);

      wait_idle();
      program_magic(CSR_SPARE_ADDR, $urandom);
      program_magic(CSR_MAGIC_ADDR, $urandom);
      send_idle_pct = 78;
      recv_idle_pct = 15;
      run_random(440);

      wait_idle();
      program_magic(CSR_MAGIC_ADDR, 32'h0000_0000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long receiver hold-off while beats keep coming
      hold_len = 120;
      hold_seq = hold_seq + 1;
      repeat (40) send_op($urandom_range(1) ? OP_APPEND : OP_READ);
      run_random(440);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mis_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(LIMIT_TICKS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
